/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the console line editor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cle_pkg.sv */
// Shared types and constants of the console line editor.
package cle_pkg;

	localparam int RING_DEPTH_DEF = 128;

	localparam logic [7:0] KEY_DEL  = 8'h7f;
	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_CR   = 8'h0d;
	localparam logic [7:0] KEY_NL   = 8'h0a;

	localparam logic [6:0] ERASE_MAX = 7'd127;

	typedef enum logic [0:0] {
		CMD_RECEIVE = 1'b0,
		CMD_READ    = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_ECHO     = 4'd0,
		ST_ERASED   = 4'd1,
		ST_FULL     = 4'd2,
		ST_NOTHING  = 4'd3,
		ST_DATA     = 4'd4,
		ST_DATA_NL  = 4'd5,
		ST_EOF      = 4'd6,
		ST_EMPTY    = 4'd7,
		ST_EOF_HELD = 4'd8
	} status_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

/* hw/rtl/cle_req_if.sv */
// Request channel of the console line editor.
interface cle_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic       read_first;

	modport source (output valid, output cmd, output rx_byte, output read_first, input ready);
	modport sink (input valid, input cmd, input rx_byte, input read_first, output ready);
endinterface

/* hw/rtl/cle_rsp_if.sv */
// Response channel of the console line editor.
interface cle_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [7:0] echo_byte;
	logic [6:0] erase_count;
	logic [7:0] read_byte;
	logic       line_committed;

	modport source (output valid, output status, output echo_byte, output erase_count,
		output read_byte, output line_committed, input ready);
	modport sink (input valid, input status, input echo_byte, input erase_count,
		input read_byte, input line_committed, output ready);
endinterface

/* hw/rtl/console_line_editor_top.sv */
// Top level of the console line editor.

// Canonical console line editor: typed bytes go into a ring of RING_DEPTH bytes with
// read, commit and edit indices; carriage return becomes newline, Delete and Ctrl-U
// erase uncommitted bytes, newline or Ctrl-D commit a line, and a read request returns
// one committed byte, end of file (held unless read_first) or empty. Every request gets
// exactly one response. The accept cycle reads the ring slot after the read index from
// the single-port ring memory (registered read); the execute state then evaluates the
// request, writes the ring and loads the response register, waiting while an earlier
// response is not yet taken. A new request is accepted only after the last executes.
// Ring contents need no clearing after reset; requests are taken right away.
module console_line_editor_top #(
	parameter int RING_DEPTH = cle_pkg::RING_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cle_req_if.sink  req,
	cle_rsp_if.source rsp
);

	cle_pkg::ctrl_cmd_t ctrl;

	cle_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctrl      (ctrl)
	);

	cle_datapath #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.cmd            (req.cmd),
		.rx_byte        (req.rx_byte),
		.read_first     (req.read_first),
		.status         (rsp.status),
		.echo_byte      (rsp.echo_byte),
		.erase_count    (rsp.erase_count),
		.read_byte      (rsp.read_byte),
		.line_committed (rsp.line_committed)
	);

endmodule

/* hw/rtl/cle_datapath.sv */
// Line ring, indices and response register of the console line editor.
`include "assert_macros.svh"

module cle_datapath #(
	parameter int RING_DEPTH = cle_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cle_pkg::ctrl_cmd_t  ctrl,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic                read_first,
	output logic [3:0]          status,
	output logic [7:0]          echo_byte,
	output logic [6:0]          erase_count,
	output logic [7:0]          read_byte,
	output logic                line_committed
);

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = (IDX_W > 7) ? IDX_W : 7;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_DEPTH - 1);

	logic [7:0]       ring_mem [RING_DEPTH];
	logic [IDX_W-1:0] read_q, commit_q, edit_q;
	logic [IDX_W-1:0] read_nx, commit_nx, edit_nx;
	logic             cmd_q, first_q;
	logic [7:0]       byte_q, rd_data_q;

	logic [IDX_W-1:0] rd_slot, ed_slot, ed_prev;
	logic [7:0]       ch;
	logic [IDX_W:0]   kill_n;
	logic [CNT_W-1:0] kill_w;
	logic             wr_en;

	cle_pkg::status_t st_nx;
	logic [7:0]       echo_nx, rbyte_nx;
	logic [6:0]       erase_nx;
	logic             commit_ev;

	assign rd_slot = (read_q == LAST) ? '0 : read_q + 1'b1;
	assign ed_slot = (edit_q == LAST) ? '0 : edit_q + 1'b1;
	assign ed_prev = (edit_q == '0) ? LAST : edit_q - 1'b1;
	assign ch      = (byte_q == cle_pkg::KEY_CR) ? cle_pkg::KEY_NL : byte_q;
	assign kill_n  = {1'b0, edit_q} - {1'b0, commit_q}
		+ ((edit_q < commit_q) ? (IDX_W+1)'(RING_DEPTH) : '0);
	assign kill_w  = CNT_W'(kill_n);

	always_comb begin
		read_nx   = read_q;
		commit_nx = commit_q;
		edit_nx   = edit_q;
		st_nx     = cle_pkg::ST_NOTHING;
		echo_nx   = '0;
		erase_nx  = '0;
		rbyte_nx  = '0;
		commit_ev = 1'b0;
		wr_en     = 1'b0;
		if (cmd_q == cle_pkg::CMD_RECEIVE) begin
			if (ch == cle_pkg::KEY_DEL) begin
				if (edit_q != commit_q) begin
					edit_nx  = ed_prev;
					st_nx    = cle_pkg::ST_ERASED;
					erase_nx = 7'd1;
				end
			end else if (ch == cle_pkg::KEY_KILL) begin
				if (edit_q != commit_q) begin
					edit_nx  = commit_q;
					st_nx    = cle_pkg::ST_ERASED;
					erase_nx = (kill_w > CNT_W'(cle_pkg::ERASE_MAX)) ?
						cle_pkg::ERASE_MAX : kill_w[6:0];
				end
			end else if (ed_slot == read_q) begin
				st_nx = cle_pkg::ST_FULL;
			end else begin
				edit_nx = ed_slot;
				wr_en   = 1'b1;
				st_nx   = cle_pkg::ST_ECHO;
				echo_nx = ch;
				if (ch == cle_pkg::KEY_NL || ch == cle_pkg::KEY_EOF) begin
					commit_nx = ed_slot;
					commit_ev = 1'b1;
				end
			end
		end else begin
			if (read_q == commit_q) begin
				st_nx = cle_pkg::ST_EMPTY;
			end else if (rd_data_q == cle_pkg::KEY_EOF) begin
				if (first_q) begin
					read_nx = rd_slot;
					st_nx   = cle_pkg::ST_EOF;
				end else begin
					st_nx = cle_pkg::ST_EOF_HELD;
				end
			end else begin
				read_nx  = rd_slot;
				rbyte_nx = rd_data_q;
				st_nx    = (rd_data_q == cle_pkg::KEY_NL) ? cle_pkg::ST_DATA_NL
					: cle_pkg::ST_DATA;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
		end else if (ctrl.execute) begin
			read_q   <= read_nx;
			commit_q <= commit_nx;
			edit_q   <= edit_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q     <= cmd;
			byte_q    <= rx_byte;
			first_q   <= read_first;
			rd_data_q <= ring_mem[rd_slot];
		end
		if (ctrl.execute && wr_en) begin
			ring_mem[ed_slot] <= ch;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			status         <= st_nx;
			echo_byte      <= echo_nx;
			erase_count    <= erase_nx;
			read_byte      <= rbyte_nx;
			line_committed <= commit_ev;
		end
	end

	`CLE_ASSERT(a_idx_hold, clk, arst_n, !ctrl.execute |=> $stable(edit_q) && $stable(read_q) && $stable(commit_q), "indices moved without execute")
	`CLE_ASSERT(a_read_behind, clk, arst_n, ctrl.execute && cmd_q == cle_pkg::CMD_READ |=> $stable(edit_q) && $stable(commit_q), "read request moved edit or commit index")
	`CLE_ASSERT_ALWAYS(a_idx_range, clk, edit_q <= LAST && read_q <= LAST && commit_q <= LAST, "ring index out of range")

endmodule

/* hw/rtl/cle_controller.sv */
// Request sequencing and response valid of the console line editor.
`include "assert_macros.svh"

module cle_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output cle_pkg::ctrl_cmd_t ctrl
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fire;

	assign in_ready     = (state_q == S_IDLE);
	assign fire         = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign ctrl.capture = in_ready && in_valid;
	assign ctrl.execute = fire;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CLE_ASSERT(a_accept_exec, clk, arst_n, ctrl.capture |=> state_q == S_EXEC, "accepted request not executed")
	`CLE_ASSERT(a_fire_valid, clk, arst_n, ctrl.execute |=> out_valid_q, "executed request gave no response")
	`CLE_ASSERT(a_cmd_excl, clk, arst_n, !(ctrl.capture && ctrl.execute), "capture and execute in one cycle")

endmodule
